>>> hw/rtl/i2cmrr_pkg.sv
// Shared types and constants for the I2C register-read master.
package i2cmrr_pkg;

   localparam int AddrWidth  = 7;
   localparam int ByteWidth  = 8;
   localparam int CountWidth = 16;
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 32;

   // One-hot sequencer states.
   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_START = 13'b0000000000010,
      ST_TXA   = 13'b0000000000100,
      ST_ACKA  = 13'b0000000001000,
      ST_TXR   = 13'b0000000010000,
      ST_ACKR  = 13'b0000000100000,
      ST_RS    = 13'b0000001000000,
      ST_TXB   = 13'b0000010000000,
      ST_ACKB  = 13'b0000100000000,
      ST_RX    = 13'b0001000000000,
      ST_RXACK = 13'b0010000000000,
      ST_STOP  = 13'b0100000000000,
      ST_STOPF = 13'b1000000000000
   } seq_state_type;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_BEGIN = 1'b1;

   localparam logic [1:0] PH_0 = 2'd0;
   localparam logic [1:0] PH_1 = 2'd1;
   localparam logic [1:0] PH_2 = 2'd2;
   localparam logic [1:0] PH_3 = 2'd3;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic                  cmd;
      logic [AddrWidth-1:0]  dev_addr;
      logic [ByteWidth-1:0]  reg_addr;
      logic [ByteWidth-1:0]  byte_count;
      logic                  sda_sample;
   } req_type;

   typedef struct packed {
      logic                  scl_release;
      logic                  sda_release;
      logic                  rx_valid;
      logic [ByteWidth-1:0]  rx_byte;
      logic                  rx_last;
      logic                  busy_res;
      logic                  done_res;
      logic                  success;
      logic [CountWidth-1:0] error_count;
   } rsp_type;

endpackage

>>> hw/rtl/i2cmrr_seq.sv
// Transaction sequencer: bus state and the result for one word.
module i2cmrr_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  i2cmrr_pkg::req_type item,
   output i2cmrr_pkg::rsp_type result
);

   i2cmrr_pkg::seq_state_type state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [6:0]  addr_ff, addr_in;
   logic [7:0]  reg_ff, reg_in;
   logic [15:0] errors_ff, errors_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic [7:0]  bytes_dec;
   logic [7:0]  rx_shift;
   logic        rv, rl, dn, ok;

   assign bytes_dec = bytes_ff - 8'd1;
   assign rx_shift  = {shift_ff[6:0], item.sda_sample};

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      bytes_in  = bytes_ff;
      addr_in   = addr_ff;
      reg_in    = reg_ff;
      errors_in = errors_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      rv = 1'b0;
      rl = 1'b0;
      dn = 1'b0;
      ok = 1'b0;
      if (state_ff == i2cmrr_pkg::ST_IDLE) begin
         if (item.cmd == i2cmrr_pkg::CMD_BEGIN) begin
            addr_in  = item.dev_addr;
            reg_in   = item.reg_addr;
            bytes_in = item.byte_count;
            scl_in   = 1'b1;
            sda_in   = 1'b1;
            state_in = i2cmrr_pkg::ST_START;
            phase_in = i2cmrr_pkg::PH_1;
            bit_in   = '0;
         end
      end else if (item.cmd == i2cmrr_pkg::CMD_TICK) begin
         case (state_ff)
            i2cmrr_pkg::ST_START: begin
               // SDA must follow what we drive; otherwise abort without STOP
               if ((!phase_ff[1] && !item.sda_sample) || (phase_ff[1] && item.sda_sample)) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  state_in = i2cmrr_pkg::ST_IDLE;
                  phase_in = i2cmrr_pkg::PH_0;
                  dn       = 1'b1;
               end else if (!phase_ff[1]) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = i2cmrr_pkg::PH_2;
               end else begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  state_in = i2cmrr_pkg::ST_TXA;
                  shift_in = {addr_ff, 1'b0};
                  bit_in   = '0;
                  phase_in = i2cmrr_pkg::PH_0;
               end
            end
            i2cmrr_pkg::ST_TXA, i2cmrr_pkg::ST_TXR, i2cmrr_pkg::ST_TXB: begin
               if (phase_ff == i2cmrr_pkg::PH_0) begin
                  scl_in   = 1'b0;
                  phase_in = i2cmrr_pkg::PH_1;
               end else if (phase_ff == i2cmrr_pkg::PH_1) begin
                  scl_in   = 1'b0;
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  phase_in = i2cmrr_pkg::PH_2;
               end else begin
                  scl_in   = 1'b1;
                  phase_in = i2cmrr_pkg::PH_0;
                  if (bit_ff != i2cmrr_pkg::LAST_BIT) begin
                     bit_in = bit_ff + 3'd1;
                  end else if (state_ff == i2cmrr_pkg::ST_TXA) begin
                     state_in = i2cmrr_pkg::ST_ACKA;
                  end else if (state_ff == i2cmrr_pkg::ST_TXR) begin
                     state_in = i2cmrr_pkg::ST_ACKR;
                  end else begin
                     state_in = i2cmrr_pkg::ST_ACKB;
                  end
               end
            end
            i2cmrr_pkg::ST_ACKA, i2cmrr_pkg::ST_ACKR, i2cmrr_pkg::ST_ACKB: begin
               case (phase_ff)
                  i2cmrr_pkg::PH_0: begin
                     scl_in   = 1'b0;
                     phase_in = i2cmrr_pkg::PH_1;
                  end
                  i2cmrr_pkg::PH_1: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = i2cmrr_pkg::PH_2;
                  end
                  i2cmrr_pkg::PH_2: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     phase_in = i2cmrr_pkg::PH_3;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = i2cmrr_pkg::PH_0;
                     if (state_ff == i2cmrr_pkg::ST_ACKA) begin
                        // only the address ACK is checked
                        if (item.sda_sample) begin
                           errors_in = errors_ff + 16'd1;
                           state_in  = i2cmrr_pkg::ST_STOPF;
                        end else begin
                           state_in = i2cmrr_pkg::ST_TXR;
                           shift_in = reg_ff;
                           bit_in   = '0;
                        end
                     end else if (state_ff == i2cmrr_pkg::ST_ACKR) begin
                        state_in = i2cmrr_pkg::ST_RS;
                     end else if (bytes_ff != 8'd0) begin
                        state_in = i2cmrr_pkg::ST_RX;
                        bit_in   = '0;
                        shift_in = '0;
                     end else begin
                        state_in = i2cmrr_pkg::ST_STOP;
                     end
                  end
               endcase
            end
            i2cmrr_pkg::ST_RS: begin
               if (phase_ff == i2cmrr_pkg::PH_0) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = i2cmrr_pkg::PH_1;
               end else if (phase_ff == i2cmrr_pkg::PH_1) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = i2cmrr_pkg::PH_2;
               end else begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  state_in = i2cmrr_pkg::ST_TXB;
                  shift_in = {addr_ff, 1'b1};
                  bit_in   = '0;
                  phase_in = i2cmrr_pkg::PH_0;
               end
            end
            i2cmrr_pkg::ST_RX: begin
               if (phase_ff == i2cmrr_pkg::PH_0) begin
                  // sample of the previous high phase lands here
                  if (bit_ff != 3'd0) begin
                     shift_in = rx_shift;
                  end
                  scl_in   = 1'b0;
                  sda_in   = 1'b1;
                  phase_in = i2cmrr_pkg::PH_1;
               end else begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = i2cmrr_pkg::PH_0;
                  if (bit_ff != i2cmrr_pkg::LAST_BIT) begin
                     bit_in = bit_ff + 3'd1;
                  end else begin
                     state_in = i2cmrr_pkg::ST_RXACK;
                  end
               end
            end
            i2cmrr_pkg::ST_RXACK: begin
               case (phase_ff)
                  i2cmrr_pkg::PH_0: begin
                     shift_in = rx_shift;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     rv       = 1'b1;
                     rl       = (bytes_ff == 8'd1);
                     phase_in = i2cmrr_pkg::PH_1;
                  end
                  i2cmrr_pkg::PH_1: begin
                     // ACK all but the last byte
                     scl_in   = 1'b0;
                     sda_in   = !(bytes_ff > 8'd1);
                     phase_in = i2cmrr_pkg::PH_2;
                  end
                  i2cmrr_pkg::PH_2: begin
                     scl_in   = 1'b1;
                     phase_in = i2cmrr_pkg::PH_3;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     phase_in = i2cmrr_pkg::PH_0;
                     bytes_in = bytes_dec;
                     if (bytes_dec == 8'd0) begin
                        state_in = i2cmrr_pkg::ST_STOP;
                     end else begin
                        state_in = i2cmrr_pkg::ST_RX;
                        bit_in   = '0;
                        shift_in = '0;
                     end
                  end
               endcase
            end
            i2cmrr_pkg::ST_STOP, i2cmrr_pkg::ST_STOPF: begin
               case (phase_ff)
                  i2cmrr_pkg::PH_0: begin
                     scl_in   = 1'b0;
                     phase_in = i2cmrr_pkg::PH_1;
                  end
                  i2cmrr_pkg::PH_1: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = i2cmrr_pkg::PH_2;
                  end
                  i2cmrr_pkg::PH_2: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                     phase_in = i2cmrr_pkg::PH_3;
                  end
                  default: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     dn       = 1'b1;
                     ok       = (state_ff == i2cmrr_pkg::ST_STOP);
                     state_in = i2cmrr_pkg::ST_IDLE;
                     phase_in = i2cmrr_pkg::PH_0;
                  end
               endcase
            end
            default: begin
               state_in = i2cmrr_pkg::ST_IDLE;
               phase_in = i2cmrr_pkg::PH_0;
            end
         endcase
      end
   end

   always_comb begin
      result.scl_release = scl_in;
      result.sda_release = sda_in;
      result.rx_valid    = rv;
      result.rx_byte     = rv ? rx_shift : 8'd0;
      result.rx_last     = rl;
      result.busy_res    = (state_in != i2cmrr_pkg::ST_IDLE);
      result.done_res    = dn;
      result.success     = ok;
      result.error_count = errors_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= i2cmrr_pkg::ST_IDLE;
         phase_ff  <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         bytes_ff  <= '0;
         addr_ff   <= '0;
         reg_ff    <= '0;
         errors_ff <= '0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
      end else if (fire) begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         bytes_ff  <= bytes_in;
         addr_ff   <= addr_in;
         reg_ff    <= reg_in;
         errors_ff <= errors_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
      end
   end

endmodule

>>> hw/rtl/i2cmrr_out.sv
// Result register holding one response word until taken.
module i2cmrr_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  i2cmrr_pkg::rsp_type data,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output i2cmrr_pkg::rsp_type rsp_word
);

   logic                valid_ff, valid_in;
   i2cmrr_pkg::rsp_type data_ff;

   assign can_load   = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_word   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

endmodule

>>> hw/rtl/i2c_master_register_read.sv
// Top level of the I2C master register-read sequencer.
//
//  channel | dir | handshake              | word
//  req     | in  | req_tvalid/req_tready  | tdata: dev_addr, reg_addr, byte_count,
//          |     |                        |   sda_sample; tuser: cmd
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: line drive, rx byte, status,
//          |     |                        |   error count; tlast: rx_last
//
// Every request word gives exactly one response word. A word is taken into
// the input register, evaluated against the bus state and moved into the
// result register; one word per cycle is sustained while rsp_tready is high.
// The rate is set by the combinational next-state logic of the sequencer.
// Reset releases both lines, clears the NACK counter and returns to idle.
// A stalled response holds the result register; the input register still
// takes one more word, after which req_tready drops until the stall clears.
module i2c_master_register_read (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] dev_addr, [14:7] reg_addr, [22:15] byte_count, [23] sda_sample
   input  logic [i2cmrr_pkg::ReqDataWidth-1:0] req_tdata,
   // [0] cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_release, [1] sda_release, [2] rx_valid, [10:3] rx_byte,
   // [11] busy_res, [12] done_res, [13] success, [29:14] error_count, [31:30] zero
   output logic [i2cmrr_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic        rsp_tlast
);

   // input register
   logic                stage_valid_ff, stage_valid_in;
   i2cmrr_pkg::req_type stage_ff;
   i2cmrr_pkg::rsp_type result;
   i2cmrr_pkg::rsp_type rsp_word;
   logic                can_load;
   logic                advance;
   logic                req_fire;

   assign advance    = stage_valid_ff && can_load;
   assign req_tready = !stage_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign stage_valid_in = req_fire || (stage_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff.cmd        <= req_tuser;
         stage_ff.dev_addr   <= req_tdata[6:0];
         stage_ff.reg_addr   <= req_tdata[14:7];
         stage_ff.byte_count <= req_tdata[22:15];
         stage_ff.sda_sample <= req_tdata[23];
      end
   end

   // bus state advances only when the word moves to the result register
   i2cmrr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (stage_ff),
      .result (result)
   );

   i2cmrr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .data       (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {2'b00, rsp_word.error_count, rsp_word.success, rsp_word.done_res,
                       rsp_word.busy_res, rsp_word.rx_byte, rsp_word.rx_valid,
                       rsp_word.sda_release, rsp_word.scl_release};
   assign rsp_tlast = rsp_word.rx_last;

   // a finished transaction is never reported busy
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_word.done_res && rsp_word.busy_res))
      else $error("done and busy in one response word");

   // success and last-byte flags only with their qualifiers
   a_flag_qual : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((!rsp_word.success || rsp_word.done_res) &&
                      (!rsp_word.rx_last || rsp_word.rx_valid)))
      else $error("status flag without its qualifier");

   // the input register is never overwritten while its word is stuck
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!stage_valid_ff || advance))
      else $error("input register overrun");

   // the NACK counter moves by at most one per evaluated word
   a_err_step : assert property (@(posedge clock) disable iff (reset)
      (advance && $past(advance) && !$past(reset)) |=>
      (rsp_word.error_count == $past(rsp_word.error_count) ||
       rsp_word.error_count == $past(rsp_word.error_count) + 16'd1))
      else $error("error count jumped");

endmodule
